/* design/mdbc_pkg.sv */
// shared types, codes and answer tables for the coin changer peripheral
package mdbc_pkg;

    localparam int COIN_CHANNELS = 6;
    localparam int CH_W = (COIN_CHANNELS > 1) ? $clog2(COIN_CHANNELS) : 1;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_BYTE  = 2'd1;
    localparam logic [1:0] OP_TXRDY = 2'd2;
    localparam logic [1:0] OP_COIN  = 2'd3;

    localparam logic [2:0] ST_ADDR   = 3'd0;
    localparam logic [2:0] ST_SUB    = 3'd1;
    localparam logic [2:0] ST_DATA   = 3'd2;
    localparam logic [2:0] ST_CHK    = 3'd3;
    localparam logic [2:0] ST_ANSWER = 3'd4;
    localparam logic [2:0] ST_ACK    = 3'd5;

    localparam logic [7:0] C_RESET     = 8'h08;
    localparam logic [7:0] C_SETUP     = 8'h09;
    localparam logic [7:0] C_TUBE      = 8'h0A;
    localparam logic [7:0] C_POLL      = 8'h0B;
    localparam logic [7:0] C_COINTYPE  = 8'h0C;
    localparam logic [7:0] C_DISPENSE  = 8'h0D;
    localparam logic [7:0] C_NOCMD     = 8'h0E;
    localparam logic [7:0] C_EXPANSION = 8'h0F;
    localparam logic [7:0] S_IDENT     = 8'h00;
    localparam logic [7:0] S_FEATURE   = 8'h01;
    localparam logic [7:0] S_DIAG      = 8'h05;
    localparam logic [7:0] B_ACK       = 8'h00;
    localparam logic [7:0] B_RET       = 8'hAA;
    localparam logic [7:0] B_NAK       = 8'hFF;
    localparam logic [7:0] ADDR_MASK   = 8'hF8;
    localparam logic [7:0] COIN_REPORT = 8'h40;

    localparam logic [2:0] LEN_UNKNOWN = 3'd7;

    localparam logic [5:0] LEN_SETUP = 6'd24;
    localparam logic [5:0] LEN_TUBE  = 6'd19;
    localparam logic [5:0] LEN_IDENT = 6'd34;
    localparam logic [5:0] LEN_DIAG  = 6'd3;

    localparam logic [2:0] E_NONE    = 3'd0;
    localparam logic [2:0] E_NOCMD   = 3'd1;
    localparam logic [2:0] E_UNKNOWN = 3'd2;
    localparam logic [2:0] E_NINTH   = 3'd3;
    localparam logic [2:0] E_RETRIES = 3'd4;
    localparam logic [2:0] E_BADACK  = 3'd5;
    localparam logic [2:0] E_TIMEOUT = 3'd6;

    localparam logic [1:0] CFG_IDLE  = 2'd0;
    localparam logic [1:0] CFG_IBYTE = 2'd1;
    localparam logic [1:0] CFG_ACK   = 2'd2;
    localparam logic [1:0] CFG_RETRY = 2'd3;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] rx_byte;
        logic       rx_mode_bit;
        logic [2:0] coin_channel;
    } t_in_item;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       tx_mode_bit;
        logic       accept_enable;
        logic [2:0] error_code;
        logic       led_on;
    } t_out_item;

    // classified event handed from the front end to the protocol engine
    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] rx_byte;
        logic       rx_mode_bit;
        logic       addr_match;
        logic       coin_ok;
        logic [CH_W-1:0] coin_idx;
        logic [2:0] cmd_len;
        logic [2:0] sub_len;
    } t_event;

    function automatic logic [2:0] data_len(input logic [7:0] c);
        case (c)
            C_RESET, C_SETUP, C_TUBE, C_POLL, S_IDENT, S_DIAG: data_len = 3'd0;
            C_COINTYPE, S_FEATURE: data_len = 3'd4;
            C_DISPENSE: data_len = 3'd1;
            default: data_len = LEN_UNKNOWN;
        endcase
    endfunction

    function automatic logic [2:0] sub_len(input logic [7:0] c);
        case (c)
            S_IDENT, S_DIAG: sub_len = 3'd0;
            S_FEATURE: sub_len = 3'd4;
            default: sub_len = LEN_UNKNOWN;
        endcase
    endfunction

    function automatic logic [7:0] setup_rom(input logic [5:0] p);
        case (p)
            6'd0: setup_rom = 8'h03;
            6'd2: setup_rom = 8'h55;
            6'd3: setup_rom = 8'h05;
            6'd4: setup_rom = 8'h02;
            6'd7: setup_rom = 8'h01;
            6'd8: setup_rom = 8'h02;
            6'd9: setup_rom = 8'h05;
            6'd10: setup_rom = 8'd10;
            6'd11: setup_rom = 8'd20;
            6'd12: setup_rom = 8'd20;
            6'd23: setup_rom = 8'h99;
            default: setup_rom = 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] ident_rom(input logic [5:0] p);
        case (p)
            6'd0: ident_rom = 8'h45;  6'd1: ident_rom = 8'h47;
            6'd2: ident_rom = 8'h53;  6'd3: ident_rom = 8'h31;
            6'd4: ident_rom = 8'h32;  6'd5: ident_rom = 8'h33;
            6'd6: ident_rom = 8'h34;  6'd7: ident_rom = 8'h35;
            6'd8: ident_rom = 8'h36;  6'd9: ident_rom = 8'h37;
            6'd10: ident_rom = 8'h38; 6'd11: ident_rom = 8'h39;
            6'd12: ident_rom = 8'h30; 6'd13: ident_rom = 8'h41;
            6'd14: ident_rom = 8'h42; 6'd15: ident_rom = 8'h45;
            6'd16: ident_rom = 8'h4D; 6'd17: ident_rom = 8'h50;
            6'd18: ident_rom = 8'h38; 6'd19: ident_rom = 8'h30;
            6'd20: ident_rom = 8'h30; 6'd21: ident_rom = 8'h30;
            6'd22: ident_rom = 8'h30; 6'd23: ident_rom = 8'h56;
            6'd24: ident_rom = 8'h34; 6'd25: ident_rom = 8'h56;
            6'd26: ident_rom = 8'h35; 6'd28: ident_rom = 8'h01;
            6'd33: ident_rom = 8'h5F;
            default: ident_rom = 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] diag_rom(input logic [5:0] p);
        case (p)
            6'd0: diag_rom = 8'h01;
            6'd2: diag_rom = 8'h01;
            default: diag_rom = 8'h00;
        endcase
    endfunction

endpackage

/* design/mdb_coin_changer_peripheral.sv */
// top level of the coin changer peripheral: front end, event queue, protocol engine
//
//  port group    direction  handshake            payload
//  event in      in         i_valid / o_stall    i_item (t_in_item)
//  result out    out        o_valid / i_stall    o_item (t_out_item)
//  config write  in         i_cfg_we             i_cfg_index, i_cfg_data
//
// one event per cycle sustained while the output is not stalled, one result beat per event
// each event passes the front register, a queue entry and the engine output register
// the engine applies each event through a combinational state update registered when taken
// synchronous active-low reset restores register defaults and clears coin counts
// a stall on the output fills the queue, then stalls the input
module mdb_coin_changer_peripheral (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  mdbc_pkg::t_in_item  i_item,
    output logic                o_valid,
    input  logic                i_stall,
    output mdbc_pkg::t_out_item o_item,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [7:0]          i_cfg_data
);

    logic             f_valid, f_stall, q_valid, q_stall;
    mdbc_pkg::t_event f_ev, q_ev;

    mdbc_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_item(i_item),
        .o_ev_valid(f_valid), .i_ev_stall(f_stall), .o_ev(f_ev)
    );

    mdbc_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(f_valid), .o_stall(f_stall), .i_ev(f_ev),
        .o_valid(q_valid), .i_stall(q_stall), .o_ev(q_ev)
    );

    mdbc_engine u_engine (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_ev_valid(q_valid), .o_ev_stall(q_stall), .i_ev(q_ev),
        .o_valid(o_valid), .i_stall(i_stall), .o_item(o_item)
    );

endmodule

/* design/mdbc_front.sv */
// input stage: accepts events and classifies address, lengths and coin channel
module mdbc_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  mdbc_pkg::t_in_item  i_item,
    output logic                o_ev_valid,
    input  logic                i_ev_stall,
    output mdbc_pkg::t_event    o_ev
);

    logic               r_valid;
    mdbc_pkg::t_event   r_ev;
    mdbc_pkg::t_event   n_ev;

    assign o_stall    = r_valid && i_ev_stall;
    assign o_ev_valid = r_valid;
    assign o_ev       = r_ev;

    always_comb begin
        n_ev.opcode      = i_item.opcode;
        n_ev.rx_byte     = i_item.rx_byte;
        n_ev.rx_mode_bit = i_item.rx_mode_bit;
        n_ev.addr_match  = (i_item.rx_byte & mdbc_pkg::ADDR_MASK) == mdbc_pkg::C_RESET;
        n_ev.coin_ok     = 32'(i_item.coin_channel) < mdbc_pkg::COIN_CHANNELS;
        n_ev.coin_idx    = mdbc_pkg::CH_W'(i_item.coin_channel);
        n_ev.cmd_len     = mdbc_pkg::data_len(i_item.rx_byte);
        n_ev.sub_len     = mdbc_pkg::sub_len(i_item.rx_byte);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
        if (!o_stall && i_valid) begin
            r_ev <= n_ev;
        end
    end

endmodule

/* design/mdbc_fifo.sv */
// two-entry event queue between the front end and the protocol engine
module mdbc_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  mdbc_pkg::t_event  i_ev,
    output logic              o_valid,
    input  logic              i_stall,
    output mdbc_pkg::t_event  o_ev
);

    mdbc_pkg::t_event r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push;
    logic       pop;

    assign o_stall = r_cnt == 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_ev    = r_mem[r_rp];
    assign push    = i_valid && !o_stall;
    assign pop     = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= !r_wp;
            if (pop) r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
        if (push) r_mem[r_wp] <= i_ev;
    end

    property p_cnt_range;
        @(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2;
    endproperty
    a_cnt_range: assert property (p_cnt_range) else $error("queue count overflow");

    property p_head_hold;
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_ev));
    endproperty
    a_head_hold: assert property (p_head_hold) else $error("queue head changed while stalled");

endmodule

/* design/mdbc_engine.sv */
// protocol engine: command parsing, answers, retries, timeouts, coin counts
module mdbc_engine (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [7:0]          i_cfg_data,
    input  logic                i_ev_valid,
    output logic                o_ev_stall,
    input  mdbc_pkg::t_event    i_ev,
    output logic                o_valid,
    input  logic                i_stall,
    output mdbc_pkg::t_out_item o_item
);

    localparam int NCH = mdbc_pkg::COIN_CHANNELS;

    logic [7:0] r_idle_lim, r_ib_lim, r_ack_lim;
    logic [2:0] r_max_retry;
    logic [2:0] r_st, n_st;
    logic [7:0] r_cmd, n_cmd;
    logic [2:0] r_drem, n_drem;
    logic [7:0] r_csum, n_csum;
    logic [7:0] r_cdata [2];
    logic [7:0] n_cdata [2];
    logic [7:0] r_abytes [3];
    logic [7:0] n_abytes [3];
    logic [5:0] r_alen, n_alen;
    logic [5:0] r_aptr, n_aptr;
    logic [2:0] r_retry, n_retry;
    logic [7:0] r_ms, n_ms;
    logic [7:0] r_lbt, n_lbt;
    logic [7:0] r_lct, n_lct;
    logic       r_rseen, n_rseen;
    logic       r_idle_to, n_idle_to;
    logic       r_acc, n_acc;
    logic [7:0] r_coins [NCH];
    logic [7:0] n_coins [NCH];
    logic       r_ovalid;
    mdbc_pkg::t_out_item r_out, n_out;

    logic       take;
    logic [2:0] dlen;
    logic [2:0] idx;
    logic       found;
    logic [15:0] mask;
    logic [7:0] ob;

    assign o_ev_stall = r_ovalid && i_stall;
    assign take       = i_ev_valid && !o_ev_stall;
    assign o_valid    = r_ovalid;
    assign o_item     = r_out;

    always_comb begin
        n_st = r_st; n_cmd = r_cmd; n_drem = r_drem; n_csum = r_csum;
        n_cdata = r_cdata; n_abytes = r_abytes; n_alen = r_alen; n_aptr = r_aptr;
        n_retry = r_retry; n_ms = r_ms; n_lbt = r_lbt; n_lct = r_lct;
        n_rseen = r_rseen; n_idle_to = r_idle_to; n_acc = r_acc; n_coins = r_coins;
        n_out = '0;
        dlen = 3'd0; idx = 3'd0; found = 1'b0; mask = 16'd0; ob = 8'd0;
        if (r_st > mdbc_pkg::ST_ACK) n_st = mdbc_pkg::ST_ADDR;
        case (i_ev.opcode)
            mdbc_pkg::OP_TICK: begin
                n_ms = r_ms + 8'd1;
                case (r_st)
                    mdbc_pkg::ST_ADDR: begin
                        if (r_rseen && r_cmd != mdbc_pkg::C_RESET && !r_idle_to &&
                            (n_ms - r_lct) > r_idle_lim) begin
                            n_acc = 1'b0; n_idle_to = 1'b1;
                        end
                    end
                    mdbc_pkg::ST_SUB, mdbc_pkg::ST_DATA, mdbc_pkg::ST_CHK: begin
                        if ((n_ms - r_lbt) > r_ib_lim) begin
                            n_st = mdbc_pkg::ST_ADDR; n_lct = n_ms;
                            n_out.error_code = mdbc_pkg::E_TIMEOUT; n_out.led_on = 1'b1;
                        end
                    end
                    mdbc_pkg::ST_ACK: begin
                        if ((n_ms - r_lbt) > r_ack_lim) begin
                            n_st = mdbc_pkg::ST_ADDR; n_lct = n_ms;
                            n_out.error_code = mdbc_pkg::E_TIMEOUT; n_out.led_on = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            mdbc_pkg::OP_BYTE: begin
                case (r_st)
                    mdbc_pkg::ST_ADDR: begin
                        if (i_ev.rx_mode_bit && i_ev.addr_match) begin
                            if (i_ev.rx_byte == mdbc_pkg::C_NOCMD) begin
                                n_st = mdbc_pkg::ST_ADDR; n_lct = r_ms;
                                n_out.error_code = mdbc_pkg::E_NOCMD; n_out.led_on = 1'b1;
                            end else begin
                                n_cmd = i_ev.rx_byte;
                                if (r_rseen || i_ev.rx_byte == mdbc_pkg::C_RESET) begin
                                    n_csum = i_ev.rx_byte;
                                    n_lbt = r_ms;
                                    if (r_idle_to) begin
                                        n_acc = 1'b1; n_idle_to = 1'b0;
                                    end
                                    if (i_ev.rx_byte == mdbc_pkg::C_EXPANSION) begin
                                        n_st = mdbc_pkg::ST_SUB;
                                    end else begin
                                        n_drem = i_ev.cmd_len;
                                        n_st = (i_ev.cmd_len == 3'd0) ? mdbc_pkg::ST_CHK
                                                                      : mdbc_pkg::ST_DATA;
                                    end
                                end
                            end
                        end
                    end
                    mdbc_pkg::ST_SUB: begin
                        n_lbt = r_ms;
                        if (i_ev.rx_mode_bit) begin
                            n_st = mdbc_pkg::ST_ADDR; n_lct = r_ms;
                            n_out.error_code = mdbc_pkg::E_NINTH; n_out.led_on = 1'b1;
                        end else begin
                            n_cmd = i_ev.rx_byte;
                            n_csum = r_csum + i_ev.rx_byte;
                            if (i_ev.sub_len == mdbc_pkg::LEN_UNKNOWN) begin
                                n_st = mdbc_pkg::ST_ADDR; n_lct = r_ms;
                                n_out.error_code = mdbc_pkg::E_UNKNOWN; n_out.led_on = 1'b1;
                            end else begin
                                n_drem = i_ev.sub_len;
                                n_st = (i_ev.sub_len == 3'd0) ? mdbc_pkg::ST_CHK
                                                              : mdbc_pkg::ST_DATA;
                            end
                        end
                    end
                    mdbc_pkg::ST_DATA: begin
                        n_lbt = r_ms;
                        if (i_ev.rx_mode_bit) begin
                            n_st = mdbc_pkg::ST_ADDR; n_lct = r_ms;
                            n_out.error_code = mdbc_pkg::E_NINTH; n_out.led_on = 1'b1;
                        end else begin
                            dlen = mdbc_pkg::data_len(r_cmd);
                            idx = dlen - r_drem;
                            if (dlen != mdbc_pkg::LEN_UNKNOWN && idx < 3'd2)
                                n_cdata[idx[0]] = i_ev.rx_byte;
                            n_csum = r_csum + i_ev.rx_byte;
                            if (r_drem != 3'd0) n_drem = r_drem - 3'd1;
                            if (n_drem == 3'd0) n_st = mdbc_pkg::ST_CHK;
                        end
                    end
                    mdbc_pkg::ST_CHK: begin
                        if (i_ev.rx_mode_bit) begin
                            n_st = mdbc_pkg::ST_ADDR; n_lct = r_ms;
                            n_out.error_code = mdbc_pkg::E_NINTH; n_out.led_on = 1'b1;
                        end else if (i_ev.rx_byte == r_csum) begin
                            n_st = mdbc_pkg::ST_ANSWER; n_aptr = 6'd0; n_retry = 3'd0;
                            n_alen = 6'd1; n_abytes[0] = mdbc_pkg::B_ACK;
                            case (r_cmd)
                                mdbc_pkg::C_RESET: begin
                                    n_acc = 1'b0; n_rseen = 1'b1;
                                end
                                mdbc_pkg::C_SETUP: n_alen = mdbc_pkg::LEN_SETUP;
                                mdbc_pkg::C_TUBE:  n_alen = mdbc_pkg::LEN_TUBE;
                                mdbc_pkg::S_IDENT: n_alen = mdbc_pkg::LEN_IDENT;
                                mdbc_pkg::S_DIAG:  n_alen = mdbc_pkg::LEN_DIAG;
                                mdbc_pkg::C_POLL: begin
                                    for (int i = 0; i < NCH; i++) begin
                                        if (!found && r_coins[i] != 8'd0) begin
                                            found = 1'b1;
                                            n_coins[i] = r_coins[i] - 8'd1;
                                            n_abytes[0] = mdbc_pkg::COIN_REPORT |
                                                          {4'd0, 4'(i)};
                                            n_abytes[1] = 8'd0;
                                            n_abytes[2] = mdbc_pkg::COIN_REPORT |
                                                          {4'd0, 4'(i)};
                                            n_alen = 6'd3;
                                        end
                                    end
                                end
                                mdbc_pkg::C_COINTYPE: begin
                                    mask = {r_cdata[0], r_cdata[1]};
                                    n_acc = 1'b0;
                                    for (int i = 0; i < NCH && i < 16; i++)
                                        if (mask[i]) n_acc = 1'b1;
                                end
                                default: ;
                            endcase
                        end else begin
                            n_st = mdbc_pkg::ST_ANSWER;
                            n_alen = 6'd1; n_aptr = 6'd0; n_abytes[0] = mdbc_pkg::B_NAK;
                        end
                    end
                    mdbc_pkg::ST_ACK: begin
                        if (i_ev.rx_mode_bit) begin
                            n_st = mdbc_pkg::ST_ADDR; n_lct = r_ms;
                            n_out.error_code = mdbc_pkg::E_NINTH; n_out.led_on = 1'b1;
                        end else if (i_ev.rx_byte == mdbc_pkg::B_ACK) begin
                            n_lct = r_ms; n_st = mdbc_pkg::ST_ADDR;
                        end else if (i_ev.rx_byte == mdbc_pkg::B_NAK ||
                                     i_ev.rx_byte == mdbc_pkg::B_RET) begin
                            if (r_retry < r_max_retry) begin
                                n_aptr = 6'd0; n_st = mdbc_pkg::ST_ANSWER;
                                n_retry = r_retry + 3'd1;
                            end else begin
                                n_st = mdbc_pkg::ST_ADDR; n_lct = r_ms;
                                n_out.error_code = mdbc_pkg::E_RETRIES; n_out.led_on = 1'b1;
                            end
                        end else begin
                            n_st = mdbc_pkg::ST_ADDR; n_lct = r_ms;
                            n_out.error_code = mdbc_pkg::E_BADACK; n_out.led_on = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            mdbc_pkg::OP_TXRDY: begin
                if (r_st == mdbc_pkg::ST_ANSWER) begin
                    if (r_cmd == mdbc_pkg::C_SETUP && r_alen == mdbc_pkg::LEN_SETUP &&
                        r_aptr < mdbc_pkg::LEN_SETUP)
                        ob = mdbc_pkg::setup_rom(r_aptr);
                    else if (r_cmd == mdbc_pkg::S_IDENT && r_alen == mdbc_pkg::LEN_IDENT &&
                             r_aptr < mdbc_pkg::LEN_IDENT)
                        ob = mdbc_pkg::ident_rom(r_aptr);
                    else if (r_cmd == mdbc_pkg::C_TUBE && r_alen == mdbc_pkg::LEN_TUBE)
                        ob = 8'd0;
                    else if (r_cmd == mdbc_pkg::S_DIAG && r_alen == mdbc_pkg::LEN_DIAG &&
                             r_aptr < mdbc_pkg::LEN_DIAG)
                        ob = mdbc_pkg::diag_rom(r_aptr);
                    else if (r_aptr < 6'd3)
                        ob = r_abytes[r_aptr[1:0]];
                    else
                        ob = 8'd0;
                    n_out.tx_valid = 1'b1;
                    n_out.tx_byte  = ob;
                    n_aptr = r_aptr + 6'd1;
                    if ({1'b0, r_aptr} + 7'd1 >= {1'b0, r_alen}) begin
                        n_out.tx_mode_bit = 1'b1;
                        if (r_alen > 6'd1) begin
                            n_st = mdbc_pkg::ST_ACK; n_lbt = r_ms;
                        end else begin
                            n_st = mdbc_pkg::ST_ADDR; n_lct = r_ms;
                        end
                    end
                end
            end
            default: begin
                if (i_ev.coin_ok && r_coins[i_ev.coin_idx] != 8'hFF)
                    n_coins[i_ev.coin_idx] = r_coins[i_ev.coin_idx] + 8'd1;
            end
        endcase
        n_out.accept_enable = n_acc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_lim <= 8'd250; r_ib_lim <= 8'd2; r_ack_lim <= 8'd8; r_max_retry <= 3'd3;
            r_st <= mdbc_pkg::ST_ADDR; r_cmd <= 8'd0; r_drem <= 3'd0; r_csum <= 8'd0;
            r_alen <= 6'd0; r_aptr <= 6'd0; r_retry <= 3'd0;
            r_ms <= 8'd0; r_lbt <= 8'd0; r_lct <= 8'd0;
            r_rseen <= 1'b0; r_idle_to <= 1'b0; r_acc <= 1'b1;
            for (int i = 0; i < NCH; i++) r_coins[i] <= 8'd0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    mdbc_pkg::CFG_IDLE:  r_idle_lim <= i_cfg_data;
                    mdbc_pkg::CFG_IBYTE: r_ib_lim <= i_cfg_data;
                    mdbc_pkg::CFG_ACK:   r_ack_lim <= i_cfg_data;
                    mdbc_pkg::CFG_RETRY: r_max_retry <= i_cfg_data[2:0];
                    default: ;
                endcase
            end
            if (!o_ev_stall) r_ovalid <= i_ev_valid;
            if (take) begin
                r_st <= n_st; r_cmd <= n_cmd; r_drem <= n_drem; r_csum <= n_csum;
                r_alen <= n_alen; r_aptr <= n_aptr; r_retry <= n_retry;
                r_ms <= n_ms; r_lbt <= n_lbt; r_lct <= n_lct;
                r_rseen <= n_rseen; r_idle_to <= n_idle_to; r_acc <= n_acc;
                r_coins <= n_coins;
            end
        end
        if (take) begin
            r_out <= n_out;
            r_cdata <= n_cdata;
            r_abytes <= n_abytes;
        end
    end

    property p_out_hold;
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && i_stall) |=> (r_ovalid && $stable(r_out));
    endproperty
    a_out_hold: assert property (p_out_hold) else $error("stalled beat changed");

    property p_led_err;
        @(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> (r_out.led_on == (r_out.error_code != mdbc_pkg::E_NONE));
    endproperty
    a_led_err: assert property (p_led_err) else $error("led and error disagree");

    property p_tx_only_answer;
        @(posedge i_clk) disable iff (!i_rst_n)
        (take && n_out.tx_valid) |-> (r_st == mdbc_pkg::ST_ANSWER);
    endproperty
    a_tx_only_answer: assert property (p_tx_only_answer) else $error("tx outside answer");

endmodule
